@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the reduction block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk_i edge, off while rst_ni is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold on a rising clk_i edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/core/ars_pkg.sv @@
// Shared constants and types of the axis reduction block.
package ars_pkg;

  localparam int unsigned MAX_INNER_DEF  = 1024;
  localparam int unsigned MAX_AXIS_DEF   = 4096;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned MODE_W      = 2;
  localparam int unsigned INNER_CFG_W = 11;
  localparam int unsigned AXIS_CFG_W  = 13;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 13;

  localparam int unsigned STORE_W = 48;  // running sum / max
  localparam int unsigned BEST_W  = 12;  // argmax position
  localparam int unsigned ENTRY_W = STORE_W + BEST_W;
  localparam int unsigned LOC_W   = 20;

  typedef enum logic [MODE_W-1:0] {
    MODE_SUM    = 2'd0,
    MODE_MAX    = 2'd1,
    MODE_ARGMAX = 2'd2
  } reduce_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE  = 2'd0,
    CFG_INNER = 2'd1,
    CFG_AXIS  = 2'd2
  } cfg_reg_e;

  // Per-element control handed to the update stage.
  typedef struct packed {
    logic              first_axis;
    logic [BEST_W-1:0] axis_idx;
    reduce_mode_e      mode;
  } upd_req_t;

endpackage

@@ rtl/core/ars_if.sv @@
// Stream interfaces for element beats in and result beats out.
interface ars_in_if #(
  parameter int unsigned DATA_WIDTH = ars_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample_value;
  logic                         first_of_tensor;

  modport source (output valid, output sample_value, output first_of_tensor, input ready);
  modport sink (input valid, input sample_value, input first_of_tensor, output ready);
endinterface

interface ars_out_if #(
  parameter int unsigned DATA_WIDTH = ars_pkg::DATA_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [DATA_WIDTH-1:0]  result_value;
  logic [ars_pkg::LOC_W-1:0]     result_location;
  logic                          result_last_outer;

  modport source (output valid, output result_value, output result_location,
                  output result_last_outer, input ready);
  modport sink (input valid, input result_value, input result_location,
                input result_last_outer, output ready);
endinterface

@@ rtl/core/axis_reduce_sum_max_argmax.sv @@
// Top level of the streaming tensor axis reduction (sum, max, argmax).
//
// Usage:
//   sample_i carries tensor elements in row-major order, one beat each,
//   with first_of_tensor set on the first element of a tensor. result_o
//   carries one beat per reduced location, sent when the element on the
//   last row of the reduced axis arrives for that inner position.
//   Configuration (mode, inner stride, axis length) is written through
//   cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle.
// Timing: the element's memory read is registered at the accepting edge
//   and its update is registered into the result_o output register when
//   the update stage retires; a held result beat can stall that stage.
// Throughput: one element per cycle while the update stage is not
//   stalled by a held result beat, set by the single read port and
//   single write port of the partial store; back-to-back updates of the
//   same entry are forwarded around the memory.
// Reset: counters and configuration return to mode sum, stride 1, length
//   1; the partial store is not cleared, every entry is loaded by the
//   first axis row of a tensor before it is read.
// Stall: a held result beat stops the update stage only when that stage
//   also has a result; sample_i.ready then drops until result_o drains.
`include "assert_macros.svh"

module axis_reduce_sum_max_argmax #(
  parameter int unsigned MAX_INNER  = ars_pkg::MAX_INNER_DEF,
  parameter int unsigned MAX_AXIS   = ars_pkg::MAX_AXIS_DEF,
  parameter int unsigned DATA_WIDTH = ars_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ars_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ars_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  ars_in_if.sink                          sample_i,
  ars_out_if.source                       result_o
);
  import ars_pkg::*;

  localparam int unsigned IW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int unsigned AW = (MAX_AXIS > 1) ? $clog2(MAX_AXIS) : 1;

  // configuration registers
  logic [MODE_W-1:0]      mode_q;
  logic [INNER_CFG_W-1:0] inner_size_q;
  logic [AXIS_CFG_W-1:0]  axis_length_q;

  // position counters
  logic [IW-1:0]    inner_q, inner_d;
  logic [AW-1:0]    axis_q, axis_d;
  logic [LOC_W-1:0] outer_q, outer_d;

  // update stage control
  logic             s1_valid_q;
  logic             s1_last_axis_q;
  logic             s1_last_inner_q;
  logic [LOC_W-1:0] s1_loc_q;

  // output register
  logic                         out_valid_q;
  logic signed [DATA_WIDTH-1:0] out_value_q;
  logic [LOC_W-1:0]             out_loc_q;
  logic                         out_last_q;

  logic [IW-1:0]    isz_m1, p0;
  logic [AW-1:0]    alen_m1, a0;
  logic [LOC_W-1:0] ob0;
  logic             last_inner_c, last_axis_c;
  logic             acc, s1_adv, upd_we;
  upd_req_t         req;
  logic signed [DATA_WIDTH-1:0] upd_result;

  // clamped sizes, minus one
  always_comb begin
    if (inner_size_q == '0)                          isz_m1 = '0;
    else if (32'(inner_size_q) > 32'(MAX_INNER))     isz_m1 = IW'(MAX_INNER - 1);
    else                                             isz_m1 = IW'(inner_size_q - 1'b1);
    if (axis_length_q == '0)                         alen_m1 = '0;
    else if (32'(axis_length_q) > 32'(MAX_AXIS))     alen_m1 = AW'(MAX_AXIS - 1);
    else                                             alen_m1 = AW'(axis_length_q - 1'b1);
  end

  // first_of_tensor clears the counters before this element
  always_comb begin
    p0 = sample_i.first_of_tensor ? '0 : inner_q;
    a0 = sample_i.first_of_tensor ? '0 : axis_q;
    ob0 = sample_i.first_of_tensor ? '0 : outer_q;
    last_inner_c = (p0 >= isz_m1);
    last_axis_c  = (a0 >= alen_m1);
    inner_d = inner_q;
    axis_d  = axis_q;
    outer_d = outer_q;
    if (acc) begin
      axis_d  = a0;
      outer_d = ob0;
      if (last_inner_c) begin
        inner_d = '0;
        if (last_axis_c) begin
          axis_d  = '0;
          outer_d = ob0 + LOC_W'(isz_m1) + LOC_W'(1);
        end else begin
          axis_d = a0 + AW'(1);
        end
      end else begin
        inner_d = p0 + IW'(1);
      end
    end
  end

  // update stage retires unless its result would overrun a held beat
  assign s1_adv = !s1_last_axis_q || !out_valid_q || result_o.ready;
  assign sample_i.ready = !s1_valid_q || s1_adv;
  assign acc    = sample_i.valid && sample_i.ready;
  assign upd_we = s1_valid_q && s1_adv;

  assign req.first_axis = (a0 == '0);
  assign req.axis_idx   = BEST_W'(a0);
  assign req.mode       = reduce_mode_e'(mode_q);

  ars_update #(
    .MAX_INNER  (MAX_INNER),
    .DATA_WIDTH (DATA_WIDTH),
    .IW         (IW)
  ) u_update (
    .clk_i    (clk_i),
    .acc_i    (acc),
    .addr_i   (p0),
    .sample_i (sample_i.sample_value),
    .req_i    (req),
    .we_i     (upd_we),
    .result_o (upd_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_SUM;
      inner_size_q  <= INNER_CFG_W'(1);
      axis_length_q <= AXIS_CFG_W'(1);
      inner_q       <= '0;
      axis_q        <= '0;
      outer_q       <= '0;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          CFG_MODE:  mode_q        <= cfg_data_i[MODE_W-1:0];
          CFG_INNER: inner_size_q  <= cfg_data_i[INNER_CFG_W-1:0];
          CFG_AXIS:  axis_length_q <= cfg_data_i[AXIS_CFG_W-1:0];
          default: ;
        endcase
      end
      inner_q <= inner_d;
      axis_q  <= axis_d;
      outer_q <= outer_d;
      if (acc)         s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;
      if (upd_we && s1_last_axis_q) out_valid_q <= 1'b1;
      else if (result_o.ready)      out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_last_axis_q  <= last_axis_c;
      s1_last_inner_q <= last_inner_c;
      s1_loc_q        <= ob0 + LOC_W'(p0);
    end
    if (upd_we && s1_last_axis_q) begin
      out_value_q <= upd_result;
      out_loc_q   <= s1_loc_q;
      out_last_q  <= s1_last_inner_q;
    end
  end

  assign result_o.valid             = out_valid_q;
  assign result_o.result_value      = out_value_q;
  assign result_o.result_location   = out_loc_q;
  assign result_o.result_last_outer = out_last_q;

  `ASSERT_NEVER(a_stall_blocks_in,
      s1_valid_q && s1_last_axis_q && out_valid_q && !result_o.ready && sample_i.ready,
      "element taken while update stage is blocked")
  `ASSERT_CLK(a_retire_shows_result,
      upd_we && s1_last_axis_q |=> result_o.valid,
      "retired last-row element gave no result beat")
  `ASSERT_CLK(a_first_restarts,
      acc && sample_i.first_of_tensor && !last_inner_c |=> inner_q == IW'(1),
      "first element of tensor did not restart inner count")

endmodule

@@ rtl/core/ars_update.sv @@
// Partial store memory with read-modify-write update and result formatting.
module ars_update #(
  parameter int unsigned MAX_INNER  = ars_pkg::MAX_INNER_DEF,
  parameter int unsigned DATA_WIDTH = ars_pkg::DATA_WIDTH_DEF,
  parameter int unsigned IW         = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1
) (
  input  logic                         clk_i,
  input  logic                         acc_i,     // element beat taken, issue read
  input  logic [IW-1:0]                addr_i,
  input  logic signed [DATA_WIDTH-1:0] sample_i,
  input  ars_pkg::upd_req_t            req_i,
  input  logic                         we_i,      // stage holding data retires
  output logic signed [DATA_WIDTH-1:0] result_o
);
  import ars_pkg::*;

  localparam int unsigned CMP_W = (DATA_WIDTH > STORE_W) ? DATA_WIDTH : STORE_W;
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  logic [ENTRY_W-1:0]           mem_q [MAX_INNER];
  logic [ENTRY_W-1:0]           rdata_q;
  logic [IW-1:0]                addr_q;
  logic signed [DATA_WIDTH-1:0] x_q;
  upd_req_t                     req_q;

  logic signed [STORE_W-1:0] x_s, cur_s, sum_s, new_cur;
  logic signed [CMP_W-1:0]   x_c, cur_c;
  logic [BEST_W-1:0]         old_idx, new_idx;
  logic [ENTRY_W-1:0]        wdata;
  logic signed [63:0]        cur64, sat64;

  always_comb begin
    x_s     = STORE_W'(x_q);
    cur_s   = signed'(rdata_q[STORE_W-1:0]);
    old_idx = rdata_q[ENTRY_W-1:STORE_W];
    x_c     = CMP_W'(x_q);
    cur_c   = CMP_W'(cur_s);
    sum_s   = cur_s + x_s;
    new_cur = cur_s;
    new_idx = old_idx;
    if (req_q.first_axis) begin
      new_cur = x_s;
      new_idx = '0;
    end else begin
      unique case (req_q.mode)
        MODE_MAX, MODE_ARGMAX: begin
          if (x_c > cur_c) begin
            new_cur = x_s;
            new_idx = req_q.axis_idx;
          end
        end
        default: new_cur = sum_s;  // sum, also the unused code
      endcase
    end
    wdata = {new_idx, new_cur};

    cur64 = 64'(new_cur);
    if (cur64 > SAT_HI)      sat64 = SAT_HI;
    else if (cur64 < SAT_LO) sat64 = SAT_LO;
    else                     sat64 = cur64;

    if (req_q.mode == MODE_ARGMAX) result_o = signed'(DATA_WIDTH'(new_idx));
    else                           result_o = DATA_WIDTH'(sat64);
  end

  // Write of the retiring element and read of the new one share an edge;
  // a read of the entry being written takes the new data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_q] <= wdata;
    end
    if (acc_i) begin
      rdata_q <= (we_i && (addr_i == addr_q)) ? wdata : mem_q[addr_i];
      addr_q  <= addr_i;
      x_q     <= sample_i;
      req_q   <= req_i;
    end
  end

endmodule
